// File: design/ild_pkg.sv
// ----------------------------------------------------------------------------
// ild_pkg
// Types, codes and helpers shared by the instruction length decoder files.
// ----------------------------------------------------------------------------
package ild_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned IMM_W   = 3;
   localparam int unsigned ADD_W   = 4;
   localparam int unsigned STAT_W  = 2;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_PREFIX = 3'd1,
      PH_REX    = 3'd2,
      PH_ESC    = 3'd3,
      PH_MODRM  = 3'd4,
      PH_SIB    = 3'd5
   } phase_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK        = 2'd0,
      ST_UNHANDLED = 2'd1,
      ST_SHORT     = 2'd2
   } status_type;

   // decode class of a byte taken as a one-byte opcode
   typedef enum logic [2:0] {
      OPC_ESCAPE,
      OPC_NO_IMM,
      OPC_IMM8,
      OPC_IMM_WIDE,
      OPC_BAD
   } opclass_type;

   localparam logic [BYTE_W-1:0] OP_OPSIZE = 8'h66;
   localparam logic [BYTE_W-1:0] OP_ESCAPE = 8'h0f;
   localparam logic [BYTE_W-1:0] OP_GRP3B  = 8'hf6;
   localparam logic [BYTE_W-1:0] OP_GRP3V  = 8'hf7;
   localparam logic [3:0]        REX_HI    = 4'h4;

   localparam logic [1:0] MOD_DISP8  = 2'd1;
   localparam logic [1:0] MOD_DISP32 = 2'd2;
   localparam logic [1:0] MOD_REG    = 2'd3;
   localparam logic [2:0] RM_SIB     = 3'd4;
   localparam logic [2:0] REG_IMM    = 3'd0;
   localparam logic [2:0] REG_BAD    = 3'd1;

   typedef struct packed {
      phase_type         phase;
      logic [BYTE_W-1:0] byte_count;
      logic              opsize_seen;
      logic              escape_seen;
      logic [BYTE_W-1:0] main_opcode;
      logic [IMM_W-1:0]  imm_bytes;
   } state_type;

   typedef struct packed {
      logic              emit;
      logic [BYTE_W-1:0] length;
      status_type        status;
   } result_type;

   localparam state_type STATE_RESET = '{
      phase:       PH_IDLE,
      byte_count:  '0,
      opsize_seen: 1'b0,
      escape_seen: 1'b0,
      main_opcode: '0,
      imm_bytes:   '0
   };

   // add with saturation at the top of the byte range
   function automatic logic [BYTE_W-1:0] sat_add(input logic [BYTE_W-1:0] a,
                                                 input logic [ADD_W-1:0] b);
      logic [BYTE_W:0] sum;
      sum = {1'b0, a} + {{(BYTE_W + 1 - ADD_W){1'b0}}, b};
      return sum[BYTE_W] ? {BYTE_W{1'b1}} : sum[BYTE_W-1:0];
   endfunction

   function automatic logic is_legacy_prefix(input logic [BYTE_W-1:0] b);
      logic hit;
      case (b)
         8'h66, 8'hf0, 8'hf2, 8'hf3, 8'h2e, 8'h36,
         8'h3e, 8'h26, 8'h64, 8'h65, 8'h67: hit = 1'b1;
         default:                           hit = 1'b0;
      endcase
      return hit;
   endfunction

   function automatic opclass_type opcode_class(input logic [BYTE_W-1:0] b);
      opclass_type cls;
      case (b)
         8'h0f:                             cls = OPC_ESCAPE;
         8'h88, 8'h89, 8'h8b, 8'h85,
         8'h38, 8'h39, 8'h3a, 8'h3b,
         8'h3c, 8'h3d, 8'hf6, 8'hf7:        cls = OPC_NO_IMM;
         8'h80, 8'h83, 8'hc6:               cls = OPC_IMM8;
         8'h81, 8'hc7:                      cls = OPC_IMM_WIDE;
         default:                           cls = OPC_BAD;
      endcase
      return cls;
   endfunction

   function automatic logic is_two_byte_op(input logic [BYTE_W-1:0] b);
      logic hit;
      case (b)
         8'h10, 8'h11, 8'hb6, 8'hb7, 8'hbe, 8'hbf: hit = 1'b1;
         default:                                 hit = 1'b0;
      endcase
      return hit;
   endfunction

endpackage

// File: design/ild_step.sv
// ----------------------------------------------------------------------------
// ild_step
// Per-byte decode: next decoder state and the result, if any, for one byte.
// ----------------------------------------------------------------------------
module ild_step (
   input  logic                           long_mode,
   input  logic [ild_pkg::BYTE_W-1:0]     code_byte,
   input  logic                           start_flag,
   input  logic                           end_flag,
   input  ild_pkg::state_type             state_cur,
   output ild_pkg::state_type             state_nxt,
   output ild_pkg::result_type            result
);

   ild_pkg::state_type            base;
   ild_pkg::opclass_type          cls;
   logic [ild_pkg::BYTE_W-1:0]    bc;
   logic [ild_pkg::IMM_W-1:0]     wide_imm;
   logic [ild_pkg::IMM_W-1:0]     imm_sel;
   logic [ild_pkg::ADD_W-1:0]     disp;
   logic [ild_pkg::BYTE_W-1:0]    total;
   logic [1:0]                    modrm_mod;
   logic [2:0]                    modrm_reg;
   logic                          grp3;
   logic                          emit;
   ild_pkg::status_type           status;
   logic [ild_pkg::BYTE_W-1:0]    len;

   always_comb begin
      base = state_cur;
      if (start_flag) begin
         base       = ild_pkg::STATE_RESET;
         base.phase = ild_pkg::PH_PREFIX;
      end
   end

   assign cls       = ild_pkg::opcode_class(code_byte);
   assign bc        = ild_pkg::sat_add(base.byte_count, ild_pkg::ADD_W'(1));
   assign wide_imm  = base.opsize_seen ? ild_pkg::IMM_W'(2) : ild_pkg::IMM_W'(4);
   assign modrm_mod = code_byte[7:6];
   assign modrm_reg = code_byte[5:3];
   assign grp3      = !base.escape_seen &&
                      (base.main_opcode == ild_pkg::OP_GRP3B ||
                       base.main_opcode == ild_pkg::OP_GRP3V);

   always_comb begin
      case (modrm_mod)
         ild_pkg::MOD_DISP8:  disp = ild_pkg::ADD_W'(1);
         ild_pkg::MOD_DISP32: disp = ild_pkg::ADD_W'(4);
         default:             disp = '0;
      endcase
   end

   // group 3 with reg 0 carries an immediate sized by the opcode
   always_comb begin
      imm_sel = base.imm_bytes;
      if (grp3 && modrm_reg == ild_pkg::REG_IMM) begin
         imm_sel = (base.main_opcode == ild_pkg::OP_GRP3B) ? ild_pkg::IMM_W'(1)
                                                           : wide_imm;
      end
   end

   assign total = ild_pkg::sat_add(bc, disp + ild_pkg::ADD_W'(imm_sel));

   always_comb begin
      state_nxt = base;
      emit      = 1'b0;
      status    = ild_pkg::ST_OK;
      len       = '0;
      state_nxt.byte_count = bc;

      case (base.phase)
         ild_pkg::PH_PREFIX, ild_pkg::PH_REX: begin
            if (base.phase == ild_pkg::PH_PREFIX &&
                ild_pkg::is_legacy_prefix(code_byte)) begin
               if (code_byte == ild_pkg::OP_OPSIZE) begin
                  state_nxt.opsize_seen = 1'b1;
               end
            end else if (base.phase == ild_pkg::PH_PREFIX && long_mode &&
                         code_byte[7:4] == ild_pkg::REX_HI) begin
               state_nxt.phase = ild_pkg::PH_REX;
            end else begin
               if (cls != ild_pkg::OPC_ESCAPE) begin
                  state_nxt.main_opcode = code_byte;
               end
               case (cls)
                  ild_pkg::OPC_ESCAPE: begin
                     state_nxt.escape_seen = 1'b1;
                     state_nxt.phase       = ild_pkg::PH_ESC;
                  end
                  ild_pkg::OPC_NO_IMM: begin
                     state_nxt.imm_bytes = '0;
                     state_nxt.phase     = ild_pkg::PH_MODRM;
                  end
                  ild_pkg::OPC_IMM8: begin
                     state_nxt.imm_bytes = ild_pkg::IMM_W'(1);
                     state_nxt.phase     = ild_pkg::PH_MODRM;
                  end
                  ild_pkg::OPC_IMM_WIDE: begin
                     state_nxt.imm_bytes = wide_imm;
                     state_nxt.phase     = ild_pkg::PH_MODRM;
                  end
                  default: begin
                     emit   = 1'b1;
                     status = ild_pkg::ST_UNHANDLED;
                  end
               endcase
            end
         end
         ild_pkg::PH_ESC: begin
            state_nxt.main_opcode = code_byte;
            state_nxt.imm_bytes   = '0;
            if (ild_pkg::is_two_byte_op(code_byte)) begin
               state_nxt.phase = ild_pkg::PH_MODRM;
            end else begin
               emit   = 1'b1;
               status = ild_pkg::ST_UNHANDLED;
            end
         end
         ild_pkg::PH_MODRM: begin
            if (grp3 && modrm_reg == ild_pkg::REG_BAD) begin
               emit   = 1'b1;
               status = ild_pkg::ST_UNHANDLED;
            end else begin
               state_nxt.imm_bytes = imm_sel;
               if (modrm_mod != ild_pkg::MOD_REG && code_byte[2:0] == ild_pkg::RM_SIB) begin
                  state_nxt.byte_count = total;
                  state_nxt.phase      = ild_pkg::PH_SIB;
               end else begin
                  emit = 1'b1;
                  len  = total;
               end
            end
         end
         ild_pkg::PH_SIB: begin
            emit = 1'b1;
            len  = bc;
         end
         default: begin
            // not inside an instruction: byte is dropped
            state_nxt = base;
            state_nxt.phase = ild_pkg::PH_IDLE;
         end
      endcase

      if (base.phase != ild_pkg::PH_IDLE && base.phase <= ild_pkg::PH_SIB &&
          !emit && end_flag) begin
         emit   = 1'b1;
         status = ild_pkg::ST_SHORT;
      end
      if (emit) begin
         state_nxt.phase = ild_pkg::PH_IDLE;
      end
   end

   assign result.emit   = emit;
   assign result.status = status;
   assign result.length = (status == ild_pkg::ST_OK) ? len : '0;

endmodule

// File: design/x86_instruction_length_decoder_core.sv
// ----------------------------------------------------------------------------
// x86_instruction_length_decoder_core
// Byte-stream length decoder for a subset of x86 / x86-64 instructions.
// ----------------------------------------------------------------------------
//   channel  direction  tdata          tuser         tlast
//   req      in         code_byte      start_flag    end_flag
//   rsp      out        length         status        -
//   csr      in         long_mode (write only, csr_we strobe)
//
// one code byte per cycle while the receiver keeps up; a result passes the
// input register, then the decode step feeding the result register, after the
// byte that completes the instruction is taken.
// reset clears the pipeline valids, the decoder state and sets long_mode.
// a stalled result holds the input register; req_tready drops only when
// both the input register and the result register are full.
module x86_instruction_length_decoder_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [ild_pkg::BYTE_W-1:0]   req_tdata,   // [7:0] code_byte
   input  logic                         req_tuser,   // [0] start_flag
   input  logic                         req_tlast,   // end_flag
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [ild_pkg::BYTE_W-1:0]   rsp_tdata,   // [7:0] length
   output logic [ild_pkg::STAT_W-1:0]   rsp_tuser,   // [1:0] status
   input  logic                         csr_we,
   input  logic                         csr_wdata    // long_mode
);

   logic                         long_mode_ff;
   logic                         in_valid_ff;
   logic [ild_pkg::BYTE_W-1:0]   in_byte_ff;
   logic                         in_start_ff;
   logic                         in_last_ff;
   ild_pkg::state_type           state_ff;
   ild_pkg::state_type           state_in;
   ild_pkg::result_type          result;
   logic                         out_valid_ff;
   logic [ild_pkg::BYTE_W-1:0]   out_len_ff;
   ild_pkg::status_type          out_stat_ff;
   logic                         out_free;
   logic                         advance;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         long_mode_ff <= 1'b1;
      end else if (csr_we) begin
         long_mode_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff  <= req_tdata;
         in_start_ff <= req_tuser;
         in_last_ff  <= req_tlast;
      end
   end

   ild_step u_step (
      .long_mode  (long_mode_ff),
      .code_byte  (in_byte_ff),
      .start_flag (in_start_ff),
      .end_flag   (in_last_ff),
      .state_cur  (state_ff),
      .state_nxt  (state_in),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ild_pkg::STATE_RESET;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && result.emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && result.emit) begin
         out_len_ff  <= result.length;
         out_stat_ff <= result.status;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_len_ff;
   assign rsp_tuser  = out_stat_ff;

endmodule

// File: tb/x86_instruction_length_decoder_core_test.sv
// ----------------------------------------------------------------------------
// x86_instruction_length_decoder_core_test
// Streams code bytes into the length decoder and checks every length/status
// transaction against a cycle-free decoder written here. The run covers both
// long_mode settings, several idling and stall mixes and one long receiver
// hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
module x86_instruction_length_decoder_core_test;
   import ild_pkg::*;

   typedef logic [BYTE_W-1:0] byte_t;
   typedef logic [12*BYTE_W-1:0] byte_list_t;   // twelve code bytes, repeats pad

   typedef struct {
      byte_t code;
      bit    first;
      bit    at_end;
   } code_item_t;

   typedef struct packed {
      byte_t      length;
      status_type status;
   } length_result_t;

   typedef struct {
      phase_type        phase;
      byte_t            count;
      bit               opsize;
      bit               escape;
      byte_t            opcode;
      logic [IMM_W-1:0] imm;
   } decoder_state_t;

   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 10;
   localparam int HOLD_OFF_CYCLES = 300;

   localparam byte_t OP_MOV_STORE    = 8'h89;
   localparam byte_t OP_ALU_IMM_WIDE = 8'h81;
   localparam byte_t OP_ALU_IMM8     = 8'h83;
   localparam byte_t OP_MOV_IMM_WIDE = 8'hc7;
   localparam byte_t OP_CMP_AL       = 8'h3c;
   localparam byte_t OP_CMP_AX       = 8'h3d;
   localparam byte_t OP_MOVZX_B      = 8'hb6;
   localparam byte_t OP_NOP          = 8'h90;
   localparam byte_t OP_INVALID      = 8'hff;
   localparam byte_t PFX_LOCK        = 8'hf0;
   localparam byte_t REX_W           = 8'h48;
   localparam logic [1:0] MOD_MEM    = 2'd0;
   localparam logic [2:0] RM_NO_BASE = 3'd5;

   localparam byte_list_t LEGACY_PREFIXES = {8'h66, 8'hf0, 8'hf2, 8'hf3, 8'h2e, 8'h36,
                                             8'h3e, 8'h26, 8'h64, 8'h65, 8'h67, 8'h66};
   localparam byte_list_t NO_IMM_OPS      = {8'h88, 8'h89, 8'h8b, 8'h85, 8'h38, 8'h39,
                                             8'h3a, 8'h3b, 8'h3c, 8'h3d, 8'hf6, 8'hf7};
   localparam byte_list_t IMM8_OPS        = {4{8'h80, 8'h83, 8'hc6}};
   localparam byte_list_t WIDE_IMM_OPS    = {6{8'h81, 8'hc7}};
   localparam byte_list_t TWO_BYTE_OPS    = {2{8'h10, 8'h11, 8'hb6, 8'hb7, 8'hbe, 8'hbf}};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   byte_t       req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   byte_t       rsp_tdata;
   logic [STAT_W-1:0] rsp_tuser;
   logic        csr_we = 1'b0;
   logic        csr_wdata = 1'b0;

   x86_instruction_length_decoder_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   code_item_t     code_bytes_q[$];
   length_result_t length_results_q[$];
   decoder_state_t dec;
   bit             long_mode_cfg = 1'b1;
   int             items_queued = 0;
   int             items_accepted = 0;
   int             mismatches = 0;
   int             cycle_count = 0;
   int             send_idle_pct = 0;
   int             recv_stall_pct = 0;
   int             hold_cycles = 0;
   bit             req_taken = 1'b0;
   code_item_t     next_item;
   length_result_t predicted, wanted;

   // ---------------------------------------------------------------- decoder

   function automatic bit byte_listed(input byte_t b, input byte_list_t tbl);
      int i;
      for (i = 0; i < 12; i++)
         if (tbl[BYTE_W*i +: BYTE_W] == b) return 1'b1;
      return 1'b0;
   endfunction

   function automatic byte_t add_capped(input byte_t a, input int b);
      int sum;
      sum = int'(a) + b;
      return (sum > 255) ? 8'hff : byte_t'(sum);
   endfunction

   function automatic bit take_opcode(input byte_t b);
      if (b == OP_ESCAPE) begin
         dec.escape = 1'b1;
         dec.phase = PH_ESC;
         return 1'b1;
      end
      dec.opcode = b;
      if (byte_listed(b, NO_IMM_OPS)) dec.imm = 3'd0;
      else if (byte_listed(b, IMM8_OPS)) dec.imm = 3'd1;
      else if (byte_listed(b, WIDE_IMM_OPS)) dec.imm = dec.opsize ? 3'd2 : 3'd4;
      else return 1'b0;
      dec.phase = PH_MODRM;
      return 1'b1;
   endfunction

   // advances the decoder by one code byte, returns 1 when a length transaction is due
   function automatic bit decode_byte(input byte_t b, input bit first, input bit at_end,
                                      output length_result_t res);
      bit         emit;
      status_type st;
      byte_t      len, total;
      logic [1:0] mode;
      logic [2:0] modrm_reg;
      int         disp;
      emit = 1'b0;
      st = ST_OK;
      len = '0;
      res.length = '0;
      res.status = ST_OK;
      if (first) begin
         dec.phase = PH_PREFIX;
         dec.count = '0;
         dec.opsize = 1'b0;
         dec.escape = 1'b0;
         dec.opcode = '0;
         dec.imm = '0;
      end
      if (dec.phase == PH_IDLE) return 1'b0;
      dec.count = add_capped(dec.count, 1);
      case (dec.phase)
         PH_PREFIX: begin
            if (byte_listed(b, LEGACY_PREFIXES)) begin
               if (b == OP_OPSIZE) dec.opsize = 1'b1;
            end else if (long_mode_cfg && b[7:4] == REX_HI) begin
               dec.phase = PH_REX;
            end else if (!take_opcode(b)) begin
               emit = 1'b1;
               st = ST_UNHANDLED;
            end
         end
         PH_REX: begin
            if (!take_opcode(b)) begin
               emit = 1'b1;
               st = ST_UNHANDLED;
            end
         end
         PH_ESC: begin
            dec.opcode = b;
            dec.imm = '0;
            if (byte_listed(b, TWO_BYTE_OPS)) begin
               dec.phase = PH_MODRM;
            end else begin
               emit = 1'b1;
               st = ST_UNHANDLED;
            end
         end
         PH_MODRM: begin
            mode = b[7:6];
            modrm_reg = b[5:3];
            disp = (mode == MOD_DISP8) ? 1 : (mode == MOD_DISP32) ? 4 : 0;
            // group 3: reg field picks test-with-immediate or a bad encoding
            if (!dec.escape && (dec.opcode == OP_GRP3B || dec.opcode == OP_GRP3V)) begin
               if (modrm_reg == REG_BAD) begin
                  emit = 1'b1;
                  st = ST_UNHANDLED;
               end else if (modrm_reg == REG_IMM) begin
                  dec.imm = (dec.opcode == OP_GRP3B) ? 3'd1 : (dec.opsize ? 3'd2 : 3'd4);
               end
            end
            if (!emit) begin
               total = add_capped(dec.count, disp + int'(dec.imm));
               if (mode != MOD_REG && b[2:0] == RM_SIB) begin
                  dec.count = total;
                  dec.phase = PH_SIB;
               end else begin
                  emit = 1'b1;
                  len = total;
               end
            end
         end
         default: begin
            emit = 1'b1;
            len = dec.count;
         end
      endcase
      if (!emit && at_end) begin
         emit = 1'b1;
         st = ST_SHORT;
      end
      if (!emit) return 1'b0;
      dec.phase = PH_IDLE;
      res.length = (st == ST_OK) ? len : '0;
      res.status = st;
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic byte_t pick(input byte_list_t tbl);
      return tbl[BYTE_W*$urandom_range(11) +: BYTE_W];
   endfunction

   function automatic byte_t modrm(input logic [1:0] mode, input logic [2:0] r,
                                   input logic [2:0] rm);
      return {mode, r, rm};
   endfunction

   task automatic queue_byte(input byte_t b, input bit first, input bit at_end);
      code_item_t it;
      it.code = b;
      it.first = first;
      it.at_end = at_end;
      code_bytes_q.push_back(it);
      items_queued++;
   endtask

   // instruction with random content, sometimes malformed, cut short or ended early
   task automatic queue_instruction();
      byte_t bytes[$];
      int    kind, cut, end_at, i;
      if ($urandom_range(9) >= 7)
         repeat ($urandom_range(1, 3)) bytes.push_back(pick(LEGACY_PREFIXES));
      if ($urandom_range(9) < 3) bytes.push_back({REX_HI, 4'($urandom_range(15))});
      kind = $urandom_range(99);
      if (kind < 20) begin
         bytes.push_back(OP_ESCAPE);
         bytes.push_back(($urandom_range(9) == 0) ? byte_t'($urandom) : pick(TWO_BYTE_OPS));
      end else if (kind < 45) bytes.push_back(pick(NO_IMM_OPS));
      else if (kind < 65) bytes.push_back(pick(IMM8_OPS));
      else if (kind < 85) bytes.push_back(pick(WIDE_IMM_OPS));
      else if (kind < 92) bytes.push_back($urandom_range(1) ? OP_GRP3B : OP_GRP3V);
      else bytes.push_back(byte_t'($urandom));
      // modrm, sib and displacement/immediate filler
      repeat (2 + $urandom_range(8)) bytes.push_back(byte_t'($urandom));
      cut = ($urandom_range(9) == 0) ? $urandom_range(1, bytes.size() - 1) : bytes.size();
      end_at = ($urandom_range(19) == 0) ? $urandom_range(cut - 1) : -1;
      for (i = 0; i < cut; i++) queue_byte(bytes[i], i == 0, i == end_at);
   endtask

   task automatic queue_random(input int n_insn);
      repeat (n_insn) begin
         if ($urandom_range(99) < 8)
            queue_byte(byte_t'($urandom), $urandom_range(3) == 0, $urandom_range(9) == 0);
         queue_instruction();
      end
   endtask

   // long prefix run so the byte count saturates
   task automatic queue_long_run(input int n_pref, input byte_t op, input byte_t mrm);
      queue_byte(pick(LEGACY_PREFIXES), 1'b1, 1'b0);
      repeat (n_pref - 1) queue_byte(pick(LEGACY_PREFIXES), 1'b0, 1'b0);
      queue_byte(op, 1'b0, 1'b0);
      queue_byte(mrm, 1'b0, 1'b0);
      repeat (4) queue_byte(byte_t'($urandom), 1'b0, 1'b0);
   endtask

   task automatic wait_idle();
      while (items_accepted != items_queued || length_results_q.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_long_mode(input bit mode_value);
      @(negedge clock);
      csr_wdata <= mode_value;
      csr_we <= 1'b1;
      @(negedge clock);
      csr_we <= 1'b0;
      long_mode_cfg = mode_value;
   endtask

   // ---------------------------------------------------------------- driver

   always @(negedge clock) begin
      if (!req_tvalid || req_taken) begin
         if (code_bytes_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            next_item = code_bytes_q.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= next_item.code;
            req_tuser <= next_item.first;
            req_tlast <= next_item.at_end;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      req_taken = 1'b0;
   end

   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            items_accepted++;
            req_taken = 1'b1;
            if (decode_byte(req_tdata, req_tuser, req_tlast, predicted))
               length_results_q.push_back(predicted);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (length_results_q.size() == 0) begin
               $display("%0t: unexpected transaction, expected none, actual length %0d status %0d",
                        $time, rsp_tdata, rsp_tuser);
               mismatches++;
            end else begin
               wanted = length_results_q.pop_front();
               if (rsp_tdata !== wanted.length) begin
                  $display("%0t: length mismatch, expected %0d actual %0d",
                           $time, wanted.length, rsp_tdata);
                  mismatches++;
               end
               if (rsp_tuser !== wanted.status) begin
                  $display("%0t: status mismatch, expected %0d actual %0d",
                           $time, wanted.status, rsp_tuser);
                  mismatches++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      dec = '{phase: PH_IDLE, count: '0, opsize: 1'b0, escape: 1'b0, opcode: '0, imm: '0};
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed, long mode as after reset
      queue_byte(OP_MOV_STORE, 1'b1, 1'b0);
      queue_byte(modrm(MOD_REG, 3'd0, 3'd0), 1'b0, 1'b0);
      queue_byte(OP_OPSIZE, 1'b1, 1'b0);
      queue_byte(OP_ALU_IMM_WIDE, 1'b0, 1'b0);
      queue_byte(modrm(MOD_DISP32, 3'd0, RM_SIB), 1'b0, 1'b0);
      queue_byte(8'h24, 1'b0, 1'b0);
      queue_byte(REX_W, 1'b1, 1'b0);
      queue_byte(OP_ESCAPE, 1'b0, 1'b0);
      queue_byte(OP_MOVZX_B, 1'b0, 1'b0);
      queue_byte(modrm(MOD_DISP8, 3'd2, RM_NO_BASE), 1'b0, 1'b0);
      queue_byte(OP_GRP3V, 1'b1, 1'b0);
      queue_byte(modrm(MOD_REG, REG_BAD, 3'd0), 1'b0, 1'b0);
      queue_byte(OP_GRP3B, 1'b1, 1'b0);
      queue_byte(modrm(MOD_MEM, REG_IMM, RM_NO_BASE), 1'b0, 1'b0);
      queue_byte(PFX_LOCK, 1'b1, 1'b0);
      queue_byte(OP_INVALID, 1'b0, 1'b0);
      queue_byte(OP_ESCAPE, 1'b1, 1'b0);
      queue_byte(OP_NOP, 1'b0, 1'b0);
      queue_byte(REX_W, 1'b1, 1'b0);
      queue_byte(REX_W, 1'b0, 1'b0);
      queue_byte(REX_W, 1'b1, 1'b0);
      queue_byte(OP_OPSIZE, 1'b0, 1'b0);
      queue_byte(OP_ALU_IMM8, 1'b1, 1'b1);
      queue_byte(OP_MOV_IMM_WIDE, 1'b1, 1'b0);
      queue_byte(modrm(MOD_MEM, 3'd0, RM_SIB), 1'b0, 1'b1);
      queue_byte(OP_CMP_AL, 1'b1, 1'b0);
      queue_byte(OP_CMP_AX, 1'b1, 1'b0);
      queue_byte(modrm(MOD_REG, 3'd7, 3'd7), 1'b0, 1'b0);
      queue_byte(OP_NOP, 1'b0, 1'b1);
      queue_byte(OP_INVALID, 1'b0, 1'b0);
      wait_idle();

      // 32-bit mode, sender mostly idle
      write_long_mode(1'b0);
      send_idle_pct = 82;
      queue_byte(REX_W, 1'b1, 1'b0);
      queue_random(19);
      wait_idle();

      // back to 64-bit mode, receiver mostly stalled, one long hold-off up front
      write_long_mode(1'b1);
      send_idle_pct = 0;
      recv_stall_pct = 82;
      @(posedge clock);
      hold_cycles = HOLD_OFF_CYCLES;
      queue_random(19);
      wait_idle();

      // both sides idle part time, plus a run that saturates the byte count
      send_idle_pct = 38;
      recv_stall_pct = 38;
      queue_long_run(260, OP_ALU_IMM_WIDE, modrm(MOD_DISP32, 3'd0, 3'd0));
      queue_random(19);
      wait_idle();

      // 32-bit mode again, full rate on both sides
      write_long_mode(1'b0);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      queue_random(19);
      wait_idle();

      if (mismatches == 0 && length_results_q.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
